### rtl/core/pfa_pkg.sv
`default_nettype none

package pfa_pkg;

  localparam int unsigned NUM_PAGES      = 1024;
  localparam int unsigned PAGE_BYTES     = 4096;
  localparam int unsigned RESERVED_PAGES = 11;

  localparam int unsigned ADDR_W   = 22;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned PAGE_W   = $clog2(NUM_PAGES);
  localparam int unsigned COUNT_W  = $clog2(NUM_PAGES + 1);
  localparam int unsigned OFF_W    = $clog2(PAGE_BYTES);

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_GRANTED = 3'd0,
    STATUS_OOM     = 3'd1,
    STATUS_BADADDR = 3'd2,
    STATUS_ALREADY = 3'd3,
    STATUS_FREED   = 3'd4
  } status_e;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] free_addr;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   page_addr;
    logic [COUNT_W-1:0]  free_count;
  } rsp_t;

endpackage

`default_nettype wire

### rtl/core/pfa_ram.sv
`default_nettype none

module pfa_ram #(
  parameter int unsigned DATA_W = 1,
  parameter int unsigned DEPTH  = 2,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/core/page_frame_allocator.sv
`default_nettype none

// Physical page allocator. Requests arrive on the input channel (in_valid_i,
// in_stall_o, in_req_i): an allocation pops a freed page from the free-page
// stack or, when the stack is empty, issues the next page never handed out.
// A free checks the address against the allocation bitmap and pushes the page.
// Each transaction yields exactly one response on the output channel
// (out_valid_o, out_stall_i, out_rsp_o) carrying status, page address and the
// number of free pages afterwards.
// The stack or bitmap memory is read in the cycle of acceptance and written
// back when the response is loaded into the output register, which waits
// while the receiver stalls. A new request is not accepted until the
// current transaction has been answered.
// After reset the stack is empty and the fresh-page counter starts above the
// reserved pages. The bitmap needs no clearing pass: any page in the
// reserved range or at or above the fresh-page counter is known not to be
// allocated, so those bits are never taken from the memory.
// When the receiver stalls, the response is held in the output register and
// a pending transaction waits until the register is free; the next request
// is then accepted as soon as the block returns to idle.
module page_frame_allocator (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire pfa_pkg::req_t  in_req_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output pfa_pkg::rsp_t       out_rsp_o
);

  import pfa_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic               state_q, state_d;
  req_t               req_q;
  logic [COUNT_W-1:0] stack_count_q, stack_count_d;
  logic [COUNT_W-1:0] next_fresh_q, next_fresh_d;
  logic               out_valid_q, out_valid_d;
  rsp_t               out_rsp_q, out_rsp_d;

  logic               in_accept;
  logic               exec_done;

  logic               stack_re;
  logic [PAGE_W-1:0]  stack_raddr;
  logic [PAGE_W-1:0]  stack_rdata;
  logic               stack_we;
  logic [PAGE_W-1:0]  stack_waddr;
  logic [PAGE_W-1:0]  stack_wdata;

  logic               bmp_re;
  logic [PAGE_W-1:0]  bmp_raddr;
  logic [0:0]         bmp_rdata;
  logic               bmp_we;
  logic [PAGE_W-1:0]  bmp_waddr;
  logic [0:0]         bmp_wdata;

  logic [ADDR_W-1:0]        free_pnum;
  logic [PAGE_W-1:0]        free_page;
  logic                     free_bad;
  logic                     free_known;
  logic                     free_bit;
  logic [PAGE_W-1:0]        alloc_page;
  logic [PAGE_W+OFF_W-1:0]  alloc_byte;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign exec_done = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);

  assign stack_re    = in_accept && (in_req_i.req_type == REQ_ALLOC) &&
                       (stack_count_q != '0);
  assign stack_raddr = PAGE_W'(stack_count_q - COUNT_W'(1));
  assign bmp_re      = in_accept && (in_req_i.req_type == REQ_FREE);
  assign bmp_raddr   = PAGE_W'(in_req_i.free_addr >> OFF_W);

  pfa_ram #(
    .DATA_W(PAGE_W),
    .DEPTH (NUM_PAGES)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (stack_we),
    .waddr_i(stack_waddr),
    .wdata_i(stack_wdata),
    .re_i   (stack_re),
    .raddr_i(stack_raddr),
    .rdata_o(stack_rdata)
  );

  pfa_ram #(
    .DATA_W(1),
    .DEPTH (NUM_PAGES)
  ) u_bitmap (
    .clk_i  (clk_i),
    .we_i   (bmp_we),
    .waddr_i(bmp_waddr),
    .wdata_i(bmp_wdata),
    .re_i   (bmp_re),
    .raddr_i(bmp_raddr),
    .rdata_o(bmp_rdata)
  );

  assign free_pnum  = req_q.free_addr >> OFF_W;
  assign free_page  = PAGE_W'(free_pnum);
  assign free_bad   = (req_q.free_addr[OFF_W-1:0] != '0) ||
                      (free_pnum >= ADDR_W'(NUM_PAGES));
  assign free_known = (COUNT_W'(free_page) >= COUNT_W'(RESERVED_PAGES)) &&
                      (COUNT_W'(free_page) < next_fresh_q);
  assign free_bit   = free_known && bmp_rdata[0];

  always_comb begin
    state_d       = state_q;
    stack_count_d = stack_count_q;
    next_fresh_d  = next_fresh_q;
    out_valid_d   = out_valid_q;
    out_rsp_d     = out_rsp_q;
    stack_we      = 1'b0;
    stack_waddr   = PAGE_W'(stack_count_q);
    stack_wdata   = free_page;
    bmp_we        = 1'b0;
    bmp_waddr     = free_page;
    bmp_wdata     = 1'b0;
    alloc_page    = '0;
    alloc_byte    = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_done) begin
          state_d              = ST_IDLE;
          out_valid_d          = 1'b1;
          out_rsp_d.page_addr  = '0;
          if (req_q.req_type == REQ_ALLOC) begin
            if (stack_count_q != '0) begin
              alloc_page    = stack_rdata;
              stack_count_d = stack_count_q - COUNT_W'(1);
              out_rsp_d.status = STATUS_GRANTED;
            end else if (next_fresh_q < COUNT_W'(NUM_PAGES)) begin
              alloc_page   = PAGE_W'(next_fresh_q);
              next_fresh_d = next_fresh_q + COUNT_W'(1);
              out_rsp_d.status = STATUS_GRANTED;
            end else begin
              out_rsp_d.status = STATUS_OOM;
            end
            if (out_rsp_d.status == STATUS_GRANTED) begin
              bmp_we              = 1'b1;
              bmp_waddr           = alloc_page;
              bmp_wdata           = 1'b1;
              alloc_byte          = {alloc_page, {OFF_W{1'b0}}};
              out_rsp_d.page_addr = ADDR_W'(alloc_byte);
            end
          end else begin
            if (free_bad) begin
              out_rsp_d.status = STATUS_BADADDR;
            end else if (!free_bit) begin
              out_rsp_d.status = STATUS_ALREADY;
            end else begin
              bmp_we = 1'b1;
              if (stack_count_q < COUNT_W'(NUM_PAGES)) begin
                stack_we      = 1'b1;
                stack_count_d = stack_count_q + COUNT_W'(1);
              end
              out_rsp_d.status = STATUS_FREED;
            end
          end
          out_rsp_d.free_count = stack_count_d + (COUNT_W'(NUM_PAGES) - next_fresh_d);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      stack_count_q <= '0;
      next_fresh_q  <= COUNT_W'(RESERVED_PAGES);
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      stack_count_q <= stack_count_d;
      next_fresh_q  <= next_fresh_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= in_req_i;
    end
    out_rsp_q <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("request accepted while another transaction is in progress");

  a_page_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, stack_count_q} + ({1'b0, COUNT_W'(NUM_PAGES)} - {1'b0, next_fresh_q}))
      <= (COUNT_W + 1)'(NUM_PAGES - RESERVED_PAGES))
    else $error("free page bookkeeping exceeds the allocatable pages");

  a_addr_only_on_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_rsp_o.status != STATUS_GRANTED)) |-> (out_rsp_o.page_addr == '0))
    else $error("page address returned on a transaction that was not granted");

  a_response_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !out_valid_q) |=> ##1 out_valid_o)
    else $error("response missing two cycles after an unblocked transaction");

endmodule

`default_nettype wire
